>>> design/oult_pkg.sv
// ----------------------------------------------------------------------------
// oult_pkg
// Shared types and constants for the ordered unique list table.
// ----------------------------------------------------------------------------
package oult_pkg;

  // Default table depth
  localparam int DEFAULT_CAPACITY = 32;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_LISTED    = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  // One result item
  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  element;
    logic                       is_empty;
    logic                       last;
  } result_t;

endpackage

>>> design/oult_outreg.sv
// ----------------------------------------------------------------------------
// oult_outreg
// Output holding register: one result slot decoupling the sequencer from
// the receiver.
// ----------------------------------------------------------------------------
module oult_outreg
  import oult_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  result_t                    din,
  output logic                       free,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VALUE_W-1:0]  element,
  output logic                       is_empty,
  output logic                       last
);

  result_t hold;

  // Slot can take a new result when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= din;
    end
  end

  assign status   = hold.status;
  assign element  = hold.element;
  assign is_empty = hold.is_empty;
  assign last     = hold.last;

  // A load never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result overwritten while stalled");

endmodule

>>> design/ordered_unique_list_table.sv
// ----------------------------------------------------------------------------
// ordered_unique_list_table
// Table of distinct 32-bit values kept in insertion order, with insert,
// delete and in-order listing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, operation, value) takes one command at
//   a time: insert, delete or list. Operation code 3 is dropped silently.
//   Output channel (out_valid/out_ready, status, element, is_empty, last)
//   returns one result per insert or delete, and one result per stored
//   value for a listing (or one empty result); last marks the final one.
//   Steps from the accepting edge to the result:
//     insert: a scan that stops at a duplicate, else covers every entry,
//             then the write of a new value at the end if there is room.
//     delete: the scan for the match, the shift down, one load.
//     list:   for each element a read, then a load of the output slot;
//             then the walk closes.
//   Every step goes through the single read port of the entry memory, one
//   entry at a time. in_ready is high only between commands. A stalled
//   receiver holds the final result in the output slot while the next
//   command is accepted; during a listing a stall pauses the walk.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_unique_list_table
  import oult_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VALUE_W-1:0]  element,
  output logic                       is_empty,
  output logic                       last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Entry memory, one read port with registered data, one write port
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;

  state_t                      state, state_next;
  op_t                         op_q;
  logic signed [VALUE_W-1:0]   value_q;
  logic [CW-1:0]               count;
  logic [CW-1:0]               ridx;
  logic [AW-1:0]               pidx;
  logic                        pend;
  status_t                     res_status;
  logic                        res_empty;

  logic                        accept;
  logic                        hit;
  logic                        walk_done;
  logic                        full;
  logic                        issue;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [VALUE_W-1:0]          wdata;
  logic                        out_free;
  logic                        out_load;
  result_t                     out_din;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign hit       = pend && (rdata == value_q);
  assign walk_done = !pend && (ridx >= count);
  assign full      = (count == CW'(CAPACITY));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(operation))
            OP_INSERT, OP_DELETE: state_next = S_SCAN;
            OP_LIST:              state_next = (count == '0) ? S_RESP : S_LIST;
            OP_NONE:              state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (op_q == OP_INSERT) ? S_RESP : S_SHIFT;
        end else if (walk_done) begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        if (walk_done) begin
          state_next = S_RESP;
        end
      end
      S_LIST: begin
        if (walk_done) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory and output controls
  always_comb begin
    issue    = 1'b0;
    we       = 1'b0;
    waddr    = count[AW-1:0];
    wdata    = value_q;
    out_load = 1'b0;
    out_din  = '{status: res_status, element: '0, is_empty: res_empty, last: 1'b1};
    unique case (state)
      S_SCAN: begin
        issue = (ridx < count) && !hit;
        we    = walk_done && (op_q == OP_INSERT) && !full;
      end
      S_SHIFT: begin
        issue = (ridx < count);
        we    = pend;
        waddr = pidx - AW'(1);
        wdata = rdata;
      end
      S_LIST: begin
        issue    = !pend && (ridx < count);
        out_load = pend && out_free;
        out_din  = '{status: ST_LISTED, element: rdata, is_empty: 1'b0,
                     last: (CW'(pidx) + CW'(1)) == count};
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata <= mem[ridx[AW-1:0]];
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ridx  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          ridx <= '0;
          pend <= 1'b0;
        end
        S_SCAN: begin
          if (hit && (op_q == OP_DELETE)) begin
            ridx <= CW'(pidx) + CW'(1);
            pend <= 1'b0;
          end else begin
            pend <= issue;
            if (issue) begin
              ridx <= ridx + CW'(1);
            end
          end
          if (we) begin
            count <= count + CW'(1);
          end
        end
        S_SHIFT: begin
          pend <= issue;
          if (issue) begin
            ridx <= ridx + CW'(1);
          end
          if (walk_done) begin
            count <= count - CW'(1);
          end
        end
        S_LIST: begin
          if (issue) begin
            pend <= 1'b1;
            ridx <= ridx + CW'(1);
          end else if (out_load) begin
            pend <= 1'b0;
          end
        end
        S_RESP: begin
          pend <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Command, read position and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op_t'(operation);
      value_q    <= value;
      res_status <= ST_LISTED;
      res_empty  <= 1'b1;
    end
    if (issue) begin
      pidx <= ridx[AW-1:0];
    end
    if (state == S_SCAN) begin
      if (hit) begin
        res_status <= ST_DUPLICATE;
        res_empty  <= 1'b0;
      end else if (walk_done) begin
        res_empty <= 1'b0;
        if (op_q == OP_DELETE) begin
          res_status <= ST_NOT_FOUND;
        end else if (full) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_INSERTED;
        end
      end
    end
    if ((state == S_SHIFT) && walk_done) begin
      res_status <= ST_DELETED;
      res_empty  <= 1'b0;
    end
  end

  oult_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .din       (out_din),
    .free      (out_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .element   (element),
    .is_empty  (is_empty),
    .last      (last)
  );

  // Table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  // No read is left in flight between commands
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend)
    else $error("read pending while idle");

  // Memory is written only during a scan or a shift
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SCAN || state == S_SHIFT))
    else $error("memory write outside scan or shift");

  // A completed shift shrinks the table by exactly one
  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && walk_done) |=> (count == $past(count) - CW'(1)))
    else $error("delete did not decrement count");

endmodule

>>> verif/ordered_unique_list_table_tb.sv
// ----------------------------------------------------------------------------
// ordered_unique_list_table_tb
// Self-checking bench for the ordered unique list table. A short directed
// walk covers the empty table, value extremes, duplicates, the full table
// and every delete position. A random phase follows that fills and drains the
// table, with random idling on the command side and random stalls on the
// result side. Every result is checked against a behavioral model or a known result.
// ----------------------------------------------------------------------------
module ordered_unique_list_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oult_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int RANDOM_CMDS = 375;
  localparam int N_DIR = 29;

  // Directed stimulus row; typed rows carry a single known result
  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  val;
    logic [5:0]                 reps;
    logic                       typed;
    status_t                    st;
    logic                       emp;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 operation = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  element;
  logic                       is_empty;
  logic                       last;

  // Model of the table contents and the results still owed by the block
  logic signed [VALUE_W-1:0]  stored_vals[$];
  result_t                    owed_results[$];
  result_t                    step_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int cmds_sent = 0;
  int empty_lists = 0;
  int status_hits [8];
  int ready_run = 0;
  bit quiet_sender = 1'b0;

  dir_row_t dir_rows [N_DIR];

  ordered_unique_list_table #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .element   (element),
    .is_empty  (is_empty),
    .last      (last)
  );

  always #4 clk = ~clk;

  function automatic result_t make_result(status_t st, logic signed [VALUE_W-1:0] el,
                                          logic emp, logic lst);
    result_t r;
    r.status   = st;
    r.element  = el;
    r.is_empty = emp;
    r.last     = lst;
    return r;
  endfunction

  // Apply one command to the table model; results land in step_results
  function automatic void table_apply(op_t op, logic signed [VALUE_W-1:0] v);
    int hit = -1;
    int n;
    step_results = {};
    foreach (stored_vals[i]) begin
      if (hit < 0 && stored_vals[i] == v) hit = i;
    end
    n = stored_vals.size();
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          step_results.push_back(make_result(ST_DUPLICATE, '0, 1'b0, 1'b1));
        end else if (n >= CAP) begin
          step_results.push_back(make_result(ST_FULL, '0, 1'b0, 1'b1));
        end else begin
          stored_vals.push_back(v);
          step_results.push_back(make_result(ST_INSERTED, '0, 1'b0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (hit < 0) begin
          step_results.push_back(make_result(ST_NOT_FOUND, '0, 1'b0, 1'b1));
        end else begin
          stored_vals.delete(hit);
          step_results.push_back(make_result(ST_DELETED, '0, 1'b0, 1'b1));
        end
      end
      OP_LIST: begin
        if (n == 0) begin
          step_results.push_back(make_result(ST_LISTED, '0, 1'b1, 1'b1));
        end else begin
          foreach (stored_vals[i])
            step_results.push_back(make_result(ST_LISTED, stored_vals[i], 1'b0, i == n - 1));
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int sender_gap();
    int r = $urandom_range(0, 99);
    if (quiet_sender || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // One command transfer; the owed results are queued at acceptance
  task automatic send_cmd(op_t op, logic signed [VALUE_W-1:0] v, logic typed,
                          result_t typed_r);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    do @(posedge clk); while (!in_ready);
    table_apply(op, v);
    if (typed) owed_results.push_back(typed_r);
    else foreach (step_results[i]) owed_results.push_back(step_results[i]);
  endtask

  // Result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin : result_side
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      status_hits[status]++;
      if (is_empty) empty_lists++;
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got status %0d element %h",
                 $time, status, element);
      end else begin
        want = owed_results.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("element", want.element, element);
        compare_field("is_empty", 32'(want.is_empty), 32'(is_empty));
        compare_field("last", 32'(want.last), 32'(last));
      end
    end
    if (ready_run > 0) begin
      ready_run--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      case ($urandom_range(0, 19))
        0:       ready_run = $urandom_range(20, 40);
        1, 2, 3: ready_run = $urandom_range(3, 8);
        default: ready_run = $urandom_range(0, 1);
      endcase
    end else begin
      out_ready <= 1'b1;
      ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 24);
    end
  end

  // Stimulus
  initial begin
    op_t                        op;
    logic signed [VALUE_W-1:0]  v;
    int                         r;
    bit                         filling;

    dir_rows = '{
      '{OP_LIST,   32'h00000000, 6'd1,  1'b1, ST_LISTED,    1'b1},  // empty listing
      '{OP_DELETE, 32'h00000005, 6'd1,  1'b1, ST_NOT_FOUND, 1'b0},  // delete from empty
      '{OP_NONE,   32'hFFFFFFFF, 6'd1,  1'b0, ST_INSERTED,  1'b0},  // unused code
      '{OP_INSERT, 32'h80000000, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_INSERT, 32'h7FFFFFFF, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_INSERT, 32'h80000000, 6'd1,  1'b1, ST_DUPLICATE, 1'b0},
      '{OP_INSERT, 32'h00000000, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_INSERT, 32'hFFFFFFFF, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_LIST,   32'h00000000, 6'd1,  1'b0, ST_LISTED,    1'b0},
      '{OP_DELETE, 32'h00000001, 6'd1,  1'b1, ST_NOT_FOUND, 1'b0},
      '{OP_DELETE, 32'h7FFFFFFF, 6'd1,  1'b1, ST_DELETED,   1'b0},  // middle entry
      '{OP_DELETE, 32'h80000000, 6'd1,  1'b1, ST_DELETED,   1'b0},  // first entry
      '{OP_DELETE, 32'hFFFFFFFF, 6'd1,  1'b1, ST_DELETED,   1'b0},  // last entry
      '{OP_DELETE, 32'h7FFFFFFF, 6'd1,  1'b1, ST_NOT_FOUND, 1'b0},  // sole entry differs
      '{OP_LIST,   32'h00000000, 6'd1,  1'b0, ST_LISTED,    1'b0},
      '{OP_DELETE, 32'h00000000, 6'd1,  1'b1, ST_DELETED,   1'b0},  // sole entry matches
      '{OP_LIST,   32'h12345678, 6'd1,  1'b1, ST_LISTED,    1'b1},
      '{OP_INSERT, 32'h55555555, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_INSERT, 32'hAAAAAAAA, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_INSERT, 32'h55555554, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_NONE,   32'h00000000, 6'd1,  1'b0, ST_INSERTED,  1'b0},
      '{OP_DELETE, 32'hAAAAAAAA, 6'd1,  1'b1, ST_DELETED,   1'b0},
      '{OP_LIST,   32'h00000000, 6'd1,  1'b0, ST_LISTED,    1'b0},
      '{OP_INSERT, 32'h00000010, 6'd30, 1'b1, ST_INSERTED,  1'b0},  // fill to capacity
      '{OP_INSERT, 32'h12345678, 6'd1,  1'b1, ST_FULL,      1'b0},
      '{OP_INSERT, 32'h55555554, 6'd1,  1'b1, ST_DUPLICATE, 1'b0},  // duplicate when full
      '{OP_DELETE, 32'h55555555, 6'd1,  1'b1, ST_DELETED,   1'b0},
      '{OP_INSERT, 32'h12345678, 6'd1,  1'b1, ST_INSERTED,  1'b0},
      '{OP_LIST,   32'h00000000, 6'd1,  1'b0, ST_LISTED,    1'b0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed walk
    for (int k = 0; k < N_DIR; k++) begin
      for (int j = 0; j < dir_rows[k].reps; j++) begin
        send_cmd(dir_rows[k].op, dir_rows[k].val + j, dir_rows[k].typed,
                 make_result(dir_rows[k].st, '0, dir_rows[k].emp, 1'b1));
      end
    end

    // Random phase: alternate between growing the table and draining it
    filling = stored_vals.size() < CAP;
    while (cmds_sent < RANDOM_CMDS) begin
      if (cmds_sent % 50 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
      if (stored_vals.size() == CAP && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (stored_vals.size() == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;

      r = $urandom_range(0, 99);
      if (r < 4) op = OP_NONE;
      else if (r < 12) op = OP_LIST;
      else if ($urandom_range(0, 99) < (filling ? 75 : 25)) op = OP_INSERT;
      else op = OP_DELETE;

      // Pick values that hit stored entries often enough to matter
      r = $urandom_range(0, 99);
      if (stored_vals.size() != 0 && r < ((op == OP_DELETE) ? 65 : 25))
        v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
      else if (r < 80)
        v = $urandom;
      else
        v = $signed($urandom_range(0, 7)) - 4;

      send_cmd(op, v, 1'b0, '0);
      if (op != OP_NONE) cmds_sent++;
    end
    in_valid <= 1'b0;

    // Drain, then allow the block time to go quiet
    while (owed_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Run covered %0d random commands after the directed walk; %0d results checked.",
             cmds_sent, results_seen);
    $display("Seen: %0d inserted, %0d duplicate, %0d full, %0d deleted, %0d not found, %0d empty.",
             status_hits[ST_INSERTED], status_hits[ST_DUPLICATE], status_hits[ST_FULL],
             status_hits[ST_DELETED], status_hits[ST_NOT_FOUND], empty_lists);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("Timeout with %0d results still owed", owed_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
design/oult_pkg.sv
design/oult_outreg.sv
design/ordered_unique_list_table.sv
verif/ordered_unique_list_table_tb.sv
